// ===== rtl/gc3_pkg.sv =====
// Shared constants, register map and tap helper for the 3x3 gray convolution.
package gc3_pkg;
    localparam int unsigned GC3_MAX_WIDTH  = 1024;
    localparam int unsigned GC3_MAX_HEIGHT = 1024;

    localparam int unsigned ACC_W = 20;   // nine 8x8 signed products
    localparam int unsigned NUM_W = 21;   // sum plus rounding term
    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_KTOP   = 3'd0;
    localparam logic [2:0] REG_KMID   = 3'd1;
    localparam logic [2:0] REG_KBOT   = 3'd2;
    localparam logic [2:0] REG_DIV    = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;
    localparam logic [2:0] REG_WIDTH  = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;

    localparam int unsigned MODE_ABS = 0;
    localparam int unsigned MODE_DIV = 1;
    localparam int unsigned MODE_SAT = 2;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [NUM_W-1:0] t_num;

    function automatic logic signed [7:0] tap_of(input logic [23:0] row,
                                                 input logic [1:0] pos);
        logic [7:0] b;
        begin
            b = 8'(row >> (5'(pos) * 5'd8));
            return $signed(b);
        end
    endfunction
endpackage

// ===== rtl/gc3_lines.sv =====
// Two line stores sharing one address, with a registered read port.
module gc3_lines #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_up,
    input  logic [7:0]    i_wr_lo,
    output logic [7:0]    o_rd_up,
    output logic [7:0]    o_rd_lo
);
    logic [7:0] r_mem_up [DEPTH];
    logic [7:0] r_mem_lo [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_up[i_wr_addr] <= i_wr_up;
            r_mem_lo[i_wr_addr] <= i_wr_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_up <= r_mem_up[i_rd_addr];
            o_rd_lo <= r_mem_lo[i_rd_addr];
        end
    end
endmodule

// ===== rtl/gc3_div.sv =====
// Signed divider, truncating toward zero, one quotient bit per cycle.
module gc3_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gc3_pkg::t_num       i_num,
    input  logic signed [7:0]   i_den,
    output logic                o_done,
    output gc3_pkg::t_num       o_quo
);
    import gc3_pkg::*;

    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_q, n_q;
    logic [8:0]    r_rem, n_rem;
    logic [7:0]    r_den, n_den;
    logic          r_neg, n_neg;
    logic          r_done, n_done;
    logic [9:0]    shifted;
    logic [7:0]    den_mag;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        den_mag = i_den[7] ? 8'(-i_den) : 8'(i_den);
        shifted = {r_rem, r_q[NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NUM_W);
            n_q    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            n_rem  = '0;
            n_den  = den_mag;
            n_neg  = i_num[NUM_W-1] ^ i_den[7];
        end else if (r_busy) begin
            if (shifted >= {2'b00, r_den}) begin
                n_rem = 9'(shifted - {2'b00, r_den});
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[8:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? t_num'(-$signed(r_q)) : t_num'($signed(r_q));
endmodule

// ===== rtl/gray_conv3x3_stream.sv =====
// Top level: 3x3 convolution over a raster stream of 8-bit gray pixels.
// One pixel word is taken at a time. A word reads both line stores at its
// column, then shifts the 3x3 window and writes the stores back; border
// positions end there. Interior positions go on to multiply-accumulate
// over the window (one kernel row per cycle), then a post step, then the
// serial divider when rounded divide is on, and last the load of the
// output register, which waits until that register is free. The output
// register holds a result until the sink takes it; the next pixel word is
// accepted meanwhile.
// o_stall is high while a word is in flight. frame_last marks the bottom
// right interior pixel. Registers sit on an APB port at byte address 4*i:
// kernel rows top/mid/bottom, divisor, post mode, width, height. Dimension
// registers are clamped to 3..MAX and should only change between frames.
module gray_conv3x3_stream #(
    parameter int unsigned MAX_WIDTH  = gc3_pkg::GC3_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = gc3_pkg::GC3_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gc3_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_pixel_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_pixel_out,
    output logic                       o_frame_last
);
    import gc3_pkg::*;

    localparam int unsigned CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // config registers
    logic [23:0] r_ktop, r_kmid, r_kbot;
    logic [7:0]  r_divisor;
    logic [2:0]  r_mode;
    logic [10:0] r_width, r_height;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_cur_col;
    logic          r_interior;
    logic          r_last;
    logic [7:0]    r_px;
    logic [7:0]    r_win [9];
    logic [1:0]    r_k;
    t_acc          r_acc;
    t_num          r_val;
    logic          r_ovalid;
    logic [7:0]    r_opix;
    logic          r_olast;

    logic          cfg_wr;
    logic [31:0]   w_eff, h_eff;
    logic [31:0]   col0, row0, col1, row1;
    logic          accept;
    logic [7:0]    rd_up, rd_lo;
    logic [23:0]   krow;
    logic signed [17:0] prod0, prod1, prod2;
    logic [7:0]    den_mag;
    logic signed [8:0] den_eff, half;
    t_num          absval, numer;
    logic          div_start, div_done;
    t_num          div_quo;
    t_num          post_v;
    logic          out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktop    <= '0;
            r_kmid    <= 24'h010000;
            r_kbot    <= '0;
            r_divisor <= 8'd1;
            r_mode    <= 3'd4;
            r_width   <= 11'd640;
            r_height  <= 11'd480;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_KTOP:   r_ktop    <= pwdata[23:0];
                REG_KMID:   r_kmid    <= pwdata[23:0];
                REG_KBOT:   r_kbot    <= pwdata[23:0];
                REG_DIV:    r_divisor <= pwdata[7:0];
                REG_MODE:   r_mode    <= pwdata[2:0];
                REG_WIDTH:  r_width   <= pwdata[10:0];
                REG_HEIGHT: r_height  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_KTOP:   prdata = {8'd0, r_ktop};
            REG_KMID:   prdata = {8'd0, r_kmid};
            REG_KBOT:   prdata = {8'd0, r_kbot};
            REG_DIV:    prdata = {24'd0, r_divisor};
            REG_MODE:   prdata = {29'd0, r_mode};
            REG_WIDTH:  prdata = {21'd0, r_width};
            REG_HEIGHT: prdata = {21'd0, r_height};
            default:    prdata = '0;
        endcase
    end

    // effective frame size
    always_comb begin
        if (r_width < 11'd3)                   w_eff = 32'd3;
        else if (32'(r_width) > MAX_WIDTH)     w_eff = MAX_WIDTH;
        else                                   w_eff = 32'(r_width);
        if (r_height < 11'd3)                  h_eff = 32'd3;
        else if (32'(r_height) > MAX_HEIGHT)   h_eff = MAX_HEIGHT;
        else                                   h_eff = 32'(r_height);
    end

    // position of the incoming word, and the position after it
    always_comb begin
        col0 = 32'(r_col);
        row0 = 32'(r_row);
        if (col0 >= w_eff) begin
            col0 = 32'd0;
            row0 = row0 + 32'd1;
        end
        if (row0 >= h_eff) row0 = 32'd0;
        col1 = col0 + 32'd1;
        row1 = row0;
        if (col1 >= w_eff) begin
            col1 = 32'd0;
            row1 = row0 + 32'd1;
            if (row1 >= h_eff) row1 = 32'd0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid & ~o_stall;

    gc3_lines #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (CW'(col0)),
        .i_wr_en   (r_state == S_RD),
        .i_wr_addr (r_cur_col),
        .i_wr_up   (rd_lo),
        .i_wr_lo   (r_px),
        .o_rd_up   (rd_up),
        .o_rd_lo   (rd_lo)
    );

    // one kernel row per MAC cycle
    always_comb begin
        unique case (r_k)
            2'd0:    krow = r_ktop;
            2'd1:    krow = r_kmid;
            default: krow = r_kbot;
        endcase
        prod0 = $signed({1'b0, r_win[3*r_k]})   * tap_of(krow, 2'd0);
        prod1 = $signed({1'b0, r_win[3*r_k+1]}) * tap_of(krow, 2'd1);
        prod2 = $signed({1'b0, r_win[3*r_k+2]}) * tap_of(krow, 2'd2);
    end

    // post steps: abs, rounding term, 0..255 clamp, divisor of zero means one
    always_comb begin
        den_eff = (r_divisor == 8'd0) ? 9'sd1 : 9'($signed(r_divisor));
        den_mag = den_eff[8] ? 8'(-den_eff) : 8'(den_eff);
        half    = $signed({2'b00, den_mag[7:1]});
        if (den_eff[8]) half = -half;
        absval  = t_num'(r_acc);
        if (r_mode[MODE_ABS] && r_acc[ACC_W-1]) absval = -absval;
        numer   = absval + t_num'(half);
        post_v  = r_val;
        if (r_mode[MODE_SAT]) begin
            if (r_val < 0)               post_v = '0;
            else if (r_val > t_num'(255)) post_v = t_num'(255);
        end
    end

    assign div_start = (r_state == S_POST) && r_mode[MODE_DIV];
    assign out_free  = ~r_ovalid | ~i_stall;

    gc3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (numer),
        .i_den   (den_eff[7:0]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_RD;
            S_RD:   n_state = r_interior ? S_MAC : S_IDLE;
            S_MAC:  if (r_k == 2'd2) n_state = S_POST;
            S_POST: n_state = r_mode[MODE_DIV] ? S_DIV : S_OUT;
            S_DIV:  if (div_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col <= CW'(col1);
                r_row <= RW'(row1);
            end
            if (r_state == S_RD) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[3*r]   <= r_win[3*r+1];
                    r_win[3*r+1] <= r_win[3*r+2];
                end
                r_win[2] <= rd_up;
                r_win[5] <= rd_lo;
                r_win[8] <= r_px;
                r_k      <= '0;
            end else if (r_state == S_MAC) begin
                r_k <= r_k + 2'd1;
            end
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (!i_stall)                r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px       <= i_pixel_in;
            r_cur_col  <= CW'(col0);
            r_interior <= (row0 >= 32'd2) && (col0 >= 32'd2);
            r_last     <= (row0 == h_eff - 32'd1) && (col0 == w_eff - 32'd1);
        end
        if (r_state == S_RD) r_acc <= '0;
        else if (r_state == S_MAC)
            r_acc <= r_acc + t_acc'(prod0) + t_acc'(prod1) + t_acc'(prod2);
        if (r_state == S_POST && !r_mode[MODE_DIV]) r_val <= absval;
        else if (r_state == S_DIV && div_done)      r_val <= div_quo;
        if (r_state == S_OUT && out_free) begin
            r_opix  <= post_v[7:0];
            r_olast <= r_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_pixel_out  = r_opix;
    assign o_frame_last = r_olast;
endmodule

// ===== tb/tb_gray_conv3x3_stream.sv =====
// Testbench for gray_conv3x3_stream: predicts every filtered pixel word and checks it.
`timescale 1ns / 100ps

module tb_gray_conv3x3_stream;
    import gc3_pkg::*;

    // Predicted filter output for one interior pixel.
    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } t_filt_word;

    // Scoreboard: shadow copy of the filter state, registers and pending outputs.
    class conv_scoreboard;
        logic [23:0] k_top, k_mid, k_bot;
        logic [7:0]  div_reg;
        logic [2:0]  mode_reg;
        logic [10:0] width_reg, height_reg;
        logic [7:0]  upper_line [GC3_MAX_WIDTH];
        logic [7:0]  lower_line [GC3_MAX_WIDTH];
        logic [7:0]  win [9];
        int unsigned col_cnt, row_cnt;
        t_filt_word  pending_q [$];
        int unsigned n_err;

        function new();
            k_top = '0; k_mid = 24'h010000; k_bot = '0;
            div_reg = 8'd1; mode_reg = 3'd4;
            width_reg = 11'd640; height_reg = 11'd480;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_cnt = 0; row_cnt = 0; n_err = 0;
        endfunction

        function int unsigned eff_dim(logic [10:0] v, int unsigned maxv);
            if (v < 3) return 3;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_KTOP:   k_top = val[23:0];
                REG_KMID:   k_mid = val[23:0];
                REG_KBOT:   k_bot = val[23:0];
                REG_DIV:    div_reg = val[7:0];
                REG_MODE:   mode_reg = val[2:0];
                REG_WIDTH:  width_reg = val[10:0];
                REG_HEIGHT: height_reg = val[10:0];
                default: ;
            endcase
        endfunction

        // Accepted pixel: advance the window and queue the filter result, if any.
        function void note_pixel(logic [7:0] px);
            int unsigned w, h, c, r;
            logic [7:0] up, lo;
            logic [23:0] krow;
            int acc, d;
            logic signed [7:0] tap;
            t_filt_word fw;
            w = eff_dim(width_reg, GC3_MAX_WIDTH);
            h = eff_dim(height_reg, GC3_MAX_HEIGHT);
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= h) row_cnt = 0;
            c = col_cnt;
            r = row_cnt;
            up = upper_line[c];
            lo = lower_line[c];
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = up; win[5] = lo; win[8] = px;
            upper_line[c] = lo;
            lower_line[c] = px;
            if (r >= 2 && c >= 2) begin
                acc = 0;
                for (int i = 0; i < 3; i++) begin
                    krow = (i == 0) ? k_top : (i == 1) ? k_mid : k_bot;
                    for (int j = 0; j < 3; j++) begin
                        tap = $signed(krow[8*j +: 8]);
                        acc += int'(win[i*3+j]) * int'(tap);
                    end
                end
                if (mode_reg[MODE_ABS] && acc < 0) acc = -acc;
                if (mode_reg[MODE_DIV]) begin
                    d = int'($signed(div_reg));
                    if (d == 0) d = 1;
                    acc = (acc + d / 2) / d;   // both truncate toward zero
                end
                if (mode_reg[MODE_SAT]) begin
                    if (acc < 0) acc = 0;
                    if (acc > 255) acc = 255;
                end
                fw.pixel = acc[7:0];
                fw.last  = (r == h - 1 && c == w - 1);
                pending_q.push_back(fw);
            end
            col_cnt = c + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt = r + 1;
                if (row_cnt >= h) row_cnt = 0;
            end
        endfunction

        function void check_word(logic [7:0] px, logic fl);
            t_filt_word fw;
            if (pending_q.size() == 0) begin
                $error("unexpected output word pixel_out=%0d frame_last=%0b", px, fl);
                n_err++;
                return;
            end
            fw = pending_q.pop_front();
            if (px !== fw.pixel) begin
                $error("pixel_out: expected %0d, actual %0d", fw.pixel, px);
                n_err++;
            end
            if (fl !== fw.last) begin
                $error("frame_last: expected %0b, actual %0b", fw.last, fl);
                n_err++;
            end
        endfunction
    endclass

    localparam int unsigned LIMIT_CYCLES = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;   // longer than the worst-case time for one word
    localparam int unsigned RAND_ITEMS   = 680;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_stall;
    logic [7:0]  i_pixel_in;
    logic        o_valid, i_stall;
    logic [7:0]  o_pixel_out;
    logic        o_frame_last;

    gray_conv3x3_stream dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_pixel_in(i_pixel_in),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_out(o_pixel_out), .o_frame_last(o_frame_last)
    );

    conv_scoreboard sb = new();

    int unsigned cycle_cnt = 0;
    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("gray_conv3x3_stream: mismatch");
            $finish;
        end
    end

    // Output monitor: check every word the sink takes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_pixel_out, o_frame_last);
    end

    // Sink stall pattern: stretches of no stall, random stall, periodic stall,
    // plus one long hold-off so the output register and the input both back up.
    initial begin
        int unsigned pat, len, k;
        forever begin
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_done = 1;
            end
            pat = $urandom_range(0, 2);
            len = $urandom_range(10, 200);
            for (k = 0; k < len; k++) begin
                case (pat)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 99) < 50);
                    default: i_stall <= (k % 4 == 3);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);    // register written at this edge
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one pixel word and hold it until accepted; gaps come between bursts.
    task automatic send_pixel(logic [7:0] px);
        int unsigned gap;
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(px);
        words_sent++;
        if (words_sent == 300) hold_req = 1;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Let the block go quiet: all results taken, then border words drained.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_frames(int unsigned nframes);
        int unsigned n;
        n = nframes * sb.eff_dim(sb.width_reg, GC3_MAX_WIDTH)
                    * sb.eff_dim(sb.height_reg, GC3_MAX_HEIGHT);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0:       send_pixel(8'd0);
                1:       send_pixel(8'd255);
                default: send_pixel(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic write_all(logic [23:0] kt, logic [23:0] km, logic [23:0] kb,
                             logic [7:0] dv, logic [2:0] md,
                             logic [10:0] w, logic [10:0] h);
        apb_write(REG_KTOP, {8'h0, kt});
        apb_write(REG_KMID, {8'h0, km});
        apb_write(REG_KBOT, {8'h0, kb});
        apb_write(REG_DIV, {24'h0, dv});
        apb_write(REG_MODE, {29'h0, md});
        apb_write(REG_WIDTH, {21'h0, w});
        apb_write(REG_HEIGHT, {21'h0, h});
    endtask

    function automatic logic [23:0] pick_row();
        case ($urandom_range(0, 5))
            0:       return 24'h808080;   // most negative taps
            1:       return 24'h7F7F7F;   // most positive taps
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_div();
        case ($urandom_range(0, 7))
            0:       return 8'h00;        // zero divisor acts as one
            1:       return 8'h80;
            2:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [10:0] pick_dim(int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return 11'($urandom_range(0, 2));   // clamps up to three
            default: return 11'($urandom_range(3, hi));
        endcase
    endfunction

    initial begin
        int unsigned base;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_valid    <= 1'b0;
        i_pixel_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: undersized dims clamp to 3x3, all taps -128, raw low byte.
        write_all(24'h808080, 24'h808080, 24'h808080, 8'h01, 3'd0, 11'd2, 11'd0);
        repeat (9) send_pixel(8'd255);
        wait_idle();
        // Directed: all taps +127, abs/divide/clamp with a zero divisor.
        write_all(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'h00, 3'd7, 11'd3, 11'd3);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
        wait_idle();

        // Random phases, mostly small frames.
        base = words_sent;
        while (words_sent - base < RAND_ITEMS) begin
            write_all(pick_row(), pick_row(), pick_row(), pick_div(),
                      3'($urandom_range(0, 7)), pick_dim(12), pick_dim(7));
            send_frames($urandom_range(1, 3));
            wait_idle();
        end

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending_q.size() == 0)
            $display("gray_conv3x3_stream: match");
        else
            $display("gray_conv3x3_stream: mismatch");
        $finish;
    end
endmodule
